[sv/dotd_pkg.sv]
// ============================================================================
// dotd_pkg: shared types and constants for the day-offset-to-date converter
// Holds the microcode word layout, the datapath operation and jump condition
// codes, the program step addresses and the calendar constants.
// ============================================================================
package dotd_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    localparam int YEAR_BITS  = 12;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int YLEN_BITS  = 9;

    // Calendar constants.
    localparam logic [YEAR_BITS-1:0]  BASE_YEAR      = 12'd1900;
    localparam logic [YLEN_BITS-1:0]  YEAR_DAYS      = 9'd365;
    localparam logic [YLEN_BITS-1:0]  LEAP_YEAR_DAYS = 9'd366;
    localparam logic [1:0]            BASE_MOD4      = 2'd0;
    localparam logic [6:0]            BASE_MOD100    = 7'd0;
    localparam logic [8:0]            BASE_MOD400    = 9'd300;
    localparam logic [6:0]            LAST_MOD100    = 7'd99;
    localparam logic [8:0]            LAST_MOD400    = 9'd399;
    localparam logic [MONTH_BITS-1:0] FIRST_MONTH    = 4'd0;
    localparam logic [MONTH_BITS-1:0] LAST_MONTH     = 4'd11;
    localparam logic [DAY_BITS-1:0]   FEB_DAYS       = 5'd28;

    // Microcode program counter and step addresses.
    typedef logic [1:0] t_upc;
    localparam t_upc STEP_LOAD  = 2'd0;
    localparam t_upc STEP_YEAR  = 2'd1;
    localparam t_upc STEP_MONTH = 2'd2;
    localparam t_upc STEP_EMIT  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SUB_YEAR,
        OP_SUB_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        COND_START,
        COND_YEAR_OVER,
        COND_MONTH_OVER,
        COND_OUT_FREE
    } t_cond;

    // One control word: the operation runs only when the condition holds.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  next_true;
        t_upc  next_false;
    } t_uword;

    // Operation strobe from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic en;
    } t_dp_ctl;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic year_over;
        logic month_over;
        logic out_free;
    } t_dp_flags;

    // Length of month m (0 is January) in days.
    function automatic logic [DAY_BITS-1:0] month_days(
        input logic [MONTH_BITS-1:0] m,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] d;
        unique case (m)
            4'd1:                       d = leap ? FEB_DAYS + 5'd1 : FEB_DAYS;
            4'd3, 4'd5, 4'd8, 4'd10:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[sv/dotd_ucode_rom.sv]
// ============================================================================
// dotd_ucode_rom: control store of the date converter
// Read-only table with one control word per program step.
// ============================================================================
module dotd_ucode_rom (
    input  dotd_pkg::t_upc   i_addr,
    output dotd_pkg::t_uword o_word
);

    always_comb begin
        unique case (i_addr)
            dotd_pkg::STEP_LOAD: begin
                o_word = '{op: dotd_pkg::OP_LOAD, cond: dotd_pkg::COND_START,
                           next_true: dotd_pkg::STEP_YEAR,
                           next_false: dotd_pkg::STEP_LOAD};
            end
            dotd_pkg::STEP_YEAR: begin
                o_word = '{op: dotd_pkg::OP_SUB_YEAR, cond: dotd_pkg::COND_YEAR_OVER,
                           next_true: dotd_pkg::STEP_YEAR,
                           next_false: dotd_pkg::STEP_MONTH};
            end
            dotd_pkg::STEP_MONTH: begin
                o_word = '{op: dotd_pkg::OP_SUB_MONTH, cond: dotd_pkg::COND_MONTH_OVER,
                           next_true: dotd_pkg::STEP_MONTH,
                           next_false: dotd_pkg::STEP_EMIT};
            end
            default: begin
                o_word = '{op: dotd_pkg::OP_EMIT, cond: dotd_pkg::COND_OUT_FREE,
                           next_true: dotd_pkg::STEP_LOAD,
                           next_false: dotd_pkg::STEP_EMIT};
            end
        endcase
    end

endmodule

[sv/dotd_sequencer.sv]
// ============================================================================
// dotd_sequencer: microprogram counter of the date converter
// Fetches the control word, tests its condition and takes one of two jumps.
// ============================================================================
module dotd_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dotd_pkg::t_dp_flags i_flags,
    output dotd_pkg::t_dp_ctl   o_ctl,
    output logic                o_at_load
);

    dotd_pkg::t_upc   r_upc;
    dotd_pkg::t_upc   n_upc;
    dotd_pkg::t_uword w_word;
    logic             w_cond;

    dotd_ucode_rom u_rom (
        .i_addr (r_upc),
        .o_word (w_word)
    );

    always_comb begin
        unique case (w_word.cond)
            dotd_pkg::COND_START:      w_cond = i_flags.start;
            dotd_pkg::COND_YEAR_OVER:  w_cond = i_flags.year_over;
            dotd_pkg::COND_MONTH_OVER: w_cond = i_flags.month_over;
            default:                   w_cond = i_flags.out_free;
        endcase
    end

    assign n_upc     = w_cond ? w_word.next_true : w_word.next_false;
    assign o_ctl     = '{op: w_word.op, en: w_cond};
    assign o_at_load = (r_upc == dotd_pkg::STEP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= dotd_pkg::STEP_LOAD;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[sv/dotd_datapath.sv]
// ============================================================================
// dotd_datapath: remaining-day register, year and month counters
// One shared subtractor removes a year or a month length per step; the
// result register holds the finished date until it is taken.
// ============================================================================
module dotd_datapath #(
    parameter int OFFSET_BITS = dotd_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dotd_pkg::t_dp_ctl                 i_ctl,
    input  logic                              i_in_valid,
    input  logic [OFFSET_BITS-1:0]            i_day_offset,
    input  logic                              i_out_ready,
    output dotd_pkg::t_dp_flags               o_flags,
    output logic                              o_out_valid,
    output logic [dotd_pkg::DAY_BITS-1:0]     o_day_of_month,
    output logic [dotd_pkg::MONTH_BITS-1:0]   o_month_number,
    output logic [dotd_pkg::YEAR_BITS-1:0]    o_year_number
);

    logic [OFFSET_BITS-1:0]             r_days,  n_days;
    logic [dotd_pkg::YEAR_BITS-1:0]     r_year,  n_year;
    logic [1:0]                         r_mod4,  n_mod4;
    logic [6:0]                         r_mod100, n_mod100;
    logic [8:0]                         r_mod400, n_mod400;
    logic [dotd_pkg::MONTH_BITS-1:0]    r_month, n_month;
    logic                               r_out_valid, n_out_valid;
    logic [dotd_pkg::DAY_BITS-1:0]      r_out_day;
    logic [dotd_pkg::MONTH_BITS-1:0]    r_out_month;
    logic [dotd_pkg::YEAR_BITS-1:0]     r_out_year;

    logic                               w_leap;
    logic [dotd_pkg::YLEN_BITS-1:0]     w_ylen;
    logic [dotd_pkg::DAY_BITS-1:0]      w_mlen;
    logic [OFFSET_BITS-1:0]             w_ylen_ext;
    logic [OFFSET_BITS-1:0]             w_mlen_ext;
    logic [OFFSET_BITS-1:0]             w_sub;
    logic [OFFSET_BITS-1:0]             w_diff;
    logic                               w_emit;

    // The year is tracked modulo 4, 100 and 400 so the leap test needs no divider.
    assign w_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign w_ylen = w_leap ? dotd_pkg::LEAP_YEAR_DAYS : dotd_pkg::YEAR_DAYS;
    assign w_mlen = dotd_pkg::month_days(r_month, w_leap);
    assign w_ylen_ext = OFFSET_BITS'(w_ylen);
    assign w_mlen_ext = OFFSET_BITS'(w_mlen);
    assign w_sub  = (i_ctl.op == dotd_pkg::OP_SUB_YEAR) ? w_ylen_ext : w_mlen_ext;
    assign w_diff = r_days - w_sub;
    assign w_emit = i_ctl.en && (i_ctl.op == dotd_pkg::OP_EMIT);

    assign o_flags = '{
        start:      i_in_valid,
        year_over:  (r_days >= w_ylen_ext),
        month_over: (r_days >= w_mlen_ext) && (r_month != dotd_pkg::LAST_MONTH),
        out_free:   !r_out_valid || i_out_ready
    };

    always_comb begin
        n_days   = r_days;
        n_year   = r_year;
        n_mod4   = r_mod4;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_month  = r_month;
        if (i_ctl.en) begin
            case (i_ctl.op)
                dotd_pkg::OP_LOAD: begin
                    n_days   = i_day_offset;
                    n_year   = dotd_pkg::BASE_YEAR;
                    n_mod4   = dotd_pkg::BASE_MOD4;
                    n_mod100 = dotd_pkg::BASE_MOD100;
                    n_mod400 = dotd_pkg::BASE_MOD400;
                    n_month  = dotd_pkg::FIRST_MONTH;
                end
                dotd_pkg::OP_SUB_YEAR: begin
                    n_days   = w_diff;
                    n_year   = r_year + 12'd1;
                    n_mod4   = r_mod4 + 2'd1;
                    n_mod100 = (r_mod100 == dotd_pkg::LAST_MOD100) ? 7'd0 : r_mod100 + 7'd1;
                    n_mod400 = (r_mod400 == dotd_pkg::LAST_MOD400) ? 9'd0 : r_mod400 + 9'd1;
                end
                dotd_pkg::OP_SUB_MONTH: begin
                    n_days  = w_diff;
                    n_month = r_month + 4'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_days   <= n_days;
        r_year   <= n_year;
        r_mod4   <= n_mod4;
        r_mod100 <= n_mod100;
        r_mod400 <= n_mod400;
        r_month  <= n_month;
        if (w_emit) begin
            // The remaining days are below the month length here, so below 31.
            r_out_day   <= r_days[dotd_pkg::DAY_BITS-1:0] + 5'd1;
            r_out_month <= r_month + 4'd1;
            r_out_year  <= r_year;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_day_of_month = r_out_day;
    assign o_month_number = r_out_month;
    assign o_year_number  = r_out_year;

endmodule

[sv/day_offset_to_date.sv]
// ============================================================================
// day_offset_to_date: day count since 1 January 1900 to Gregorian date
// Microcoded converter: a four-step program in a small control store drives
// a datapath that subtracts whole years, then whole months, one per cycle.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -------------------------------
//  in        request    i_in_valid / o_in_ready     i_day_offset
//  out       result     o_out_valid / i_out_ready   o_day_of_month, o_month_number,
//                                                   o_year_number
//
//  Flow: a request is taken in the load step; the program then removes the
//  whole years and then the whole months (at most 11) from the offset, one
//  year or one month length per cycle through the single shared subtractor,
//  and the emit step writes the result. The next request is taken only when
//  the program has returned to the load step after the emit step.
//  Reset: i_rst_n is synchronous and active low; it returns the program
//  counter to the load step and empties the result register.
//  Stalls: a finished result waits in the output register while the next
//  request is loaded and converted; the program holds on its final step only
//  if the previous result has still not been taken.
//
module day_offset_to_date #(
    parameter int OFFSET_BITS = dotd_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [OFFSET_BITS-1:0]            i_day_offset,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dotd_pkg::DAY_BITS-1:0]     o_day_of_month,
    output logic [dotd_pkg::MONTH_BITS-1:0]   o_month_number,
    output logic [dotd_pkg::YEAR_BITS-1:0]    o_year_number
);

    dotd_pkg::t_dp_ctl   w_ctl;
    dotd_pkg::t_dp_flags w_flags;
    logic                w_at_load;

    // The sequencer walks the program; its load step is the only one that
    // takes a request.
    dotd_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flags   (w_flags),
        .o_ctl     (w_ctl),
        .o_at_load (w_at_load)
    );

    // The datapath keeps the remaining days, the year with its leap
    // residues, the month index and the result register.
    dotd_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_in_valid     (i_in_valid),
        .i_day_offset   (i_day_offset),
        .i_out_ready    (i_out_ready),
        .o_flags        (w_flags),
        .o_out_valid    (o_out_valid),
        .o_day_of_month (o_day_of_month),
        .o_month_number (o_month_number),
        .o_year_number  (o_year_number)
    );

    assign o_in_ready = w_at_load;

    // After a request is taken the program is busy with the year step.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("request accepted while a conversion was starting");

    // A result shown on the port always carries a real month.
    a_month_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month_number >= 4'd1) && (o_month_number <= 4'd12)
    ) else $error("month out of range");

    // A result shown on the port always carries a real day of month.
    a_day_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day_of_month >= 5'd1) && (o_day_of_month <= 5'd31)
    ) else $error("day of month out of range");

endmodule
